[hdl/jdke_pkg.sv]
package jdke_pkg;

  // Width of one converter sample
  localparam int unsigned SAMPLE_BITS = 12;

  localparam int unsigned CENTER_BITS = 12;
  localparam int unsigned HALF_BITS   = 11;

  // Signed working width for band edges: covers sample, center + half and center - half
  localparam int unsigned CALC_W =
      ((SAMPLE_BITS > CENTER_BITS) ? SAMPLE_BITS : CENTER_BITS) + 3;

  localparam int unsigned MAX_EVENTS = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [2:0] KC_LEFT   = 3'd0;
  localparam logic [2:0] KC_RIGHT  = 3'd1;
  localparam logic [2:0] KC_SLEFT  = 3'd2;
  localparam logic [2:0] KC_SRIGHT = 3'd3;
  localparam logic [2:0] KC_UP     = 3'd4;
  localparam logic [2:0] KC_DOWN   = 3'd5;

  localparam logic [CENTER_BITS-1:0] HCENTER_RST = 12'd1500;
  localparam logic [CENTER_BITS-1:0] VCENTER_RST = 12'd2048;
  localparam logic [HALF_BITS-1:0]   HALF_RST    = 11'd600;
  localparam logic [HALF_BITS-1:0]   MARGIN_RST  = 11'd200;

  typedef enum logic [1:0] {
    REG_HCENTER = 2'd0,
    REG_VCENTER = 2'd1,
    REG_HALF    = 2'd2,
    REG_MARGIN  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CENTER_BITS-1:0] hcenter;
    logic [CENTER_BITS-1:0] vcenter;
    logic [HALF_BITS-1:0]   half;
    logic [HALF_BITS-1:0]   margin;
  } cfg_t;

  typedef struct packed {
    logic [2:0] code;
    logic       press;
  } event_t;

  // One poll's worth of events, oldest in slot 0
  typedef struct packed {
    logic [2:0]                 cnt;
    event_t [MAX_EVENTS-1:0]    ev;
  } entry_t;

endpackage

[hdl/jdke_front.sv]
module jdke_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  jdke_pkg::cfg_t                    cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [jdke_pkg::SAMPLE_BITS-1:0]  horizontal_sample_i,
  input  logic [jdke_pkg::SAMPLE_BITS-1:0]  vertical_sample_i,
  input  logic                              strafe_press_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output jdke_pkg::entry_t                  q_data_o
);
  import jdke_pkg::*;

  typedef struct packed {
    logic         low;
    logic         high;
    logic [1:0]   cnt;
    event_t [1:0] ev;
  } axis_res_t;

  function automatic axis_res_t judge_axis(
    input logic [SAMPLE_BITS-1:0] s,
    input logic [CENTER_BITS-1:0] c,
    input logic [HALF_BITS-1:0]   half,
    input logic [HALF_BITS-1:0]   m,
    input logic                   low,
    input logic                   high,
    input logic [2:0]             low_code,
    input logic [2:0]             high_code
  );
    logic signed [CALC_W-1:0] sv;
    logic signed [CALC_W-1:0] lo;
    logic signed [CALC_W-1:0] hi;
    logic signed [CALC_W-1:0] mv;
    axis_res_t r;
    sv = signed'(CALC_W'(s));
    mv = signed'(CALC_W'(m));
    lo = signed'(CALC_W'(c)) - signed'(CALC_W'(half)) + (low ? mv : '0);
    hi = signed'(CALC_W'(c)) + signed'(CALC_W'(half)) - (high ? mv : '0);
    r = '0;
    r.low  = low;
    r.high = high;
    if (sv <= hi && sv >= lo) begin
      if (low) begin
        r.low = 1'b0;
        r.ev[0] = '{code: low_code, press: 1'b0};
        r.cnt = 2'd1;
      end
      if (high) begin
        r.high = 1'b0;
        r.ev[r.cnt[0]] = '{code: high_code, press: 1'b0};
        r.cnt = r.cnt + 2'd1;
      end
    end else if (sv < lo) begin
      if (!low) begin
        r.low = 1'b1;
        r.ev[0] = '{code: low_code, press: 1'b1};
        r.cnt = 2'd1;
      end
      if (high) begin
        r.high = 1'b0;
        r.ev[r.cnt[0]] = '{code: high_code, press: 1'b0};
        r.cnt = r.cnt + 2'd1;
      end
    end else begin
      if (!high) begin
        r.high = 1'b1;
        r.ev[0] = '{code: high_code, press: 1'b1};
        r.cnt = 2'd1;
      end
      if (low) begin
        r.low = 1'b0;
        r.ev[r.cnt[0]] = '{code: low_code, press: 1'b0};
        r.cnt = r.cnt + 2'd1;
      end
    end
    return r;
  endfunction

  logic left_q, right_q, up_q, down_q, strafe_q;
  logic strafe_d;
  logic in_fire;
  axis_res_t h_res, v_res;
  entry_t    ent;

  assign in_ready_o = !q_full_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign strafe_d   = strafe_q ^ strafe_press_i;

  always_comb begin
    h_res = judge_axis(horizontal_sample_i, cfg_i.hcenter, cfg_i.half, cfg_i.margin,
                       left_q, right_q,
                       strafe_d ? KC_SLEFT : KC_LEFT,
                       strafe_d ? KC_SRIGHT : KC_RIGHT);
    v_res = judge_axis(vertical_sample_i, cfg_i.vcenter, cfg_i.half, cfg_i.margin,
                       up_q, down_q, KC_UP, KC_DOWN);
  end

  // Pack horizontal events first, vertical ones right behind
  always_comb begin
    ent     = '0;
    ent.cnt = {1'b0, h_res.cnt} + {1'b0, v_res.cnt};
    for (int i = 0; i < 2; i++) begin
      if (2'(i) < h_res.cnt) ent.ev[2'(i)] = h_res.ev[i];
    end
    for (int j = 0; j < 2; j++) begin
      if (2'(j) < v_res.cnt) ent.ev[2'(h_res.cnt + 2'(j))] = v_res.ev[j];
    end
  end

  assign q_push_o = in_fire && (ent.cnt != 3'd0);
  assign q_data_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= 1'b0;
      right_q  <= 1'b0;
      up_q     <= 1'b0;
      down_q   <= 1'b0;
      strafe_q <= 1'b0;
    end else if (in_fire) begin
      left_q   <= h_res.low;
      right_q  <= h_res.high;
      up_q     <= v_res.low;
      down_q   <= v_res.high;
      strafe_q <= strafe_d;
    end
  end

  a_opposite_never_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(left_q && right_q) && !(up_q && down_q))
    else $error("opposite directions held together");

  a_strafe_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && strafe_press_i) |=> (strafe_q != $past(strafe_q)))
    else $error("strafe mode did not flip on press");

endmodule

[hdl/jdke_queue.sv]
module jdke_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  jdke_pkg::entry_t  data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output jdke_pkg::entry_t  data_o
);
  import jdke_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wptr_q, rptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slots_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("poll dropped: queue full");

endmodule

[hdl/jdke_back.sv]
module jdke_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  jdke_pkg::entry_t  q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        key_code_o,
  output logic              is_press_o,
  output logic              last_of_poll_o
);
  import jdke_pkg::*;

  entry_t     cur_q;
  logic       cur_v_q;
  logic [1:0] idx_q;
  logic       out_v_q;
  logic [2:0] key_q;
  logic       press_q, last_q;
  logic       load, cur_last;
  event_t     ev_sel;

  assign load     = !out_v_q || out_ready_i;
  assign cur_last = ({1'b0, idx_q} == (cur_q.cnt - 3'd1));
  assign ev_sel   = cur_q.ev[idx_q];
  assign q_pop_o  = q_valid_i && (!cur_v_q || (load && cur_last));

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= q_data_i;
    if (load && cur_v_q) begin
      key_q   <= ev_sel.code;
      press_q <= ev_sel.press;
      last_q  <= cur_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      idx_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (load) out_v_q <= cur_v_q;
      if (q_pop_o) begin
        cur_v_q <= 1'b1;
        idx_q   <= '0;
      end else if (load && cur_v_q) begin
        if (cur_last) cur_v_q <= 1'b0;
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  assign out_valid_o    = out_v_q;
  assign key_code_o     = key_q;
  assign is_press_o     = press_q;
  assign last_of_poll_o = last_q;

  a_cur_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_v_q |-> (cur_q.cnt != 3'd0) && ({1'b0, idx_q} < cur_q.cnt))
    else $error("event index beyond poll's event count");

endmodule

[hdl/joystick_deadzone_key_events_top.sv]
// Joystick dead-zone key event generator. Each accepted poll carries a
// horizontal and a vertical sample plus a strafe-button flag; the flag flips
// strafe mode before the axes are judged. Each axis has a neutral band of
// center +/- deadzone_half_width, and a held direction pulls its own band edge
// inward by hysteresis_margin. A poll produces zero to four key events,
// horizontal first, each a request on the result channel, and the final
// event of a poll carries last_of_poll. A poll that changes nothing produces
// no request at all. Timing: the front end judges a poll in the cycle it is
// accepted and pushes its events as one entry into a two-entry queue; the
// back end drains one event per cycle through an output register while the
// result channel is ready, so the sustained rate is one result request per
// clock, and polls keep streaming in while the queue has room. Configuration
// registers sit at byte offsets 0x0 horizontal_center, 0x4 vertical_center,
// 0x8 deadzone_half_width and 0xC hysteresis_margin; write them only while
// no poll is in flight. Registers reset to 1500, 2048, 600 and 200.
module joystick_deadzone_key_events_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // poll channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [jdke_pkg::SAMPLE_BITS-1:0]  horizontal_sample_i,
  input  logic [jdke_pkg::SAMPLE_BITS-1:0]  vertical_sample_i,
  input  logic                              strafe_press_i,
  // key event channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        key_code_o,
  output logic                              is_press_o,
  output logic                              last_of_poll_o
);
  import jdke_pkg::*;

  cfg_t     cfg_q;
  logic     cfg_wr;
  reg_idx_e reg_idx;

  logic   q_push, q_full, q_pop, q_valid;
  entry_t q_wdata, q_rdata;

  // Register file: write on the access phase, pready tied high
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hcenter <= HCENTER_RST;
      cfg_q.vcenter <= VCENTER_RST;
      cfg_q.half    <= HALF_RST;
      cfg_q.margin  <= MARGIN_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_HCENTER: cfg_q.hcenter <= pwdata[CENTER_BITS-1:0];
        REG_VCENTER: cfg_q.vcenter <= pwdata[CENTER_BITS-1:0];
        REG_HALF:    cfg_q.half    <= pwdata[HALF_BITS-1:0];
        REG_MARGIN:  cfg_q.margin  <= pwdata[HALF_BITS-1:0];
        default:     ;
      endcase
    end
  end

  // Read back, zero-extended to the bus width
  always_comb begin
    unique case (reg_idx)
      REG_HCENTER: prdata = 32'(cfg_q.hcenter);
      REG_VCENTER: prdata = 32'(cfg_q.vcenter);
      REG_HALF:    prdata = 32'(cfg_q.half);
      REG_MARGIN:  prdata = 32'(cfg_q.margin);
      default:     prdata = '0;
    endcase
  end

  // Front end: judge the poll, update held flags, push its events
  jdke_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .horizontal_sample_i (horizontal_sample_i),
    .vertical_sample_i   (vertical_sample_i),
    .strafe_press_i      (strafe_press_i),
    .q_full_i            (q_full),
    .q_push_o            (q_push),
    .q_data_o            (q_wdata)
  );

  // Hold pending polls so either side can stall independently
  jdke_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  // Back end: drain one event per cycle into the output register while out_ready_i allows
  jdke_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_rdata),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .key_code_o     (key_code_o),
    .is_press_o     (is_press_o),
    .last_of_poll_o (last_of_poll_o)
  );

endmodule

[sim/tb_joystick_deadzone_key_events_top.sv]
module tb_joystick_deadzone_key_events_top;
  timeunit 1ns;
  timeprecision 1ps;

  import jdke_pkg::*;

  // Abort after this many cycles with no request moving on any port
  localparam int unsigned IDLE_LIMIT = 1000;
  // Quiet cycles after the last event, so a poll that emits nothing is done
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;

  typedef struct {
    logic [2:0] code;
    logic       press;
    logic       last;
  } key_event_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [3:0]             paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [SAMPLE_BITS-1:0] horizontal_sample_i;
  logic [SAMPLE_BITS-1:0] vertical_sample_i;
  logic                   strafe_press_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [2:0]             key_code_o;
  logic                   is_press_o;
  logic                   last_of_poll_o;

  joystick_deadzone_key_events_top u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .horizontal_sample_i (horizontal_sample_i),
    .vertical_sample_i   (vertical_sample_i),
    .strafe_press_i      (strafe_press_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .key_code_o          (key_code_o),
    .is_press_o          (is_press_o),
    .last_of_poll_o      (last_of_poll_o)
  );

  // Key events still owed by the block, oldest first
  key_event_t  pending_keys[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  // Set to run a stretch with no gaps and no back-pressure
  bit          quiet;

  // Shadow copy of the block's registers and held flags
  logic [CENTER_BITS-1:0] hcenter_m;
  logic [CENTER_BITS-1:0] vcenter_m;
  logic [HALF_BITS-1:0]   half_m;
  logic [HALF_BITS-1:0]   margin_m;
  bit                     left_m;
  bit                     right_m;
  bit                     up_m;
  bit                     down_m;
  bit                     strafe_m;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns: MISMATCH %s", $time, msg);
  endtask

  function automatic void add_key(input logic [2:0] code, input logic press);
    key_event_t e;
    e.code  = code;
    e.press = press;
    e.last  = 1'b0;
    pending_keys.push_back(e);
  endfunction

  // Judge one axis against its band; a held side pulls its own edge inward.
  // A sample under the low edge wins when hysteresis crosses the edges.
  function automatic void judge_axis(input int s, input int c,
                                     inout bit low, inout bit high,
                                     input logic [2:0] low_code,
                                     input logic [2:0] high_code);
    int lo;
    int hi;
    lo = c - int'(half_m) + (low ? int'(margin_m) : 0);
    hi = c + int'(half_m) - (high ? int'(margin_m) : 0);
    if (s >= lo && s <= hi) begin
      if (low) begin
        low = 1'b0;
        add_key(low_code, 1'b0);
      end
      if (high) begin
        high = 1'b0;
        add_key(high_code, 1'b0);
      end
    end else if (s < lo) begin
      if (!low) begin
        low = 1'b1;
        add_key(low_code, 1'b1);
      end
      if (high) begin
        high = 1'b0;
        add_key(high_code, 1'b0);
      end
    end else begin
      if (!high) begin
        high = 1'b1;
        add_key(high_code, 1'b1);
      end
      if (low) begin
        low = 1'b0;
        add_key(low_code, 1'b0);
      end
    end
  endfunction

  // Flip strafe first, then horizontal events, then vertical ones; tag the
  // final event of the poll.
  function automatic void predict_poll(input logic [SAMPLE_BITS-1:0] h,
                                       input logic [SAMPLE_BITS-1:0] v,
                                       input logic s);
    int first;
    first = pending_keys.size();
    if (s) strafe_m = !strafe_m;
    judge_axis(int'(h), int'(hcenter_m), left_m, right_m,
               strafe_m ? KC_SLEFT : KC_LEFT,
               strafe_m ? KC_SRIGHT : KC_RIGHT);
    judge_axis(int'(v), int'(vcenter_m), up_m, down_m, KC_UP, KC_DOWN);
    if (pending_keys.size() > first) pending_keys[pending_keys.size() - 1].last = 1'b1;
  endfunction

  // Watch all three ports at each edge: check events, predict polls, track
  // register writes, and keep the stall counter for the watchdog.
  always @(posedge clk_i) begin : port_monitor
    bit         busy;
    key_event_t want;
    busy = 1'b0;
    if (rst_ni) begin
      // Check the event first: it always belongs to an earlier poll
      if (out_valid_o && out_ready_i) begin
        busy = 1'b1;
        if (pending_keys.size() == 0) begin
          report_mismatch($sformatf("unexpected event code %0d press %0b last %0b",
                                    key_code_o, is_press_o, last_of_poll_o));
        end else begin
          want = pending_keys.pop_front();
          if (key_code_o !== want.code)
            report_mismatch($sformatf("key_code %0d, want %0d", key_code_o, want.code));
          if (is_press_o !== want.press)
            report_mismatch($sformatf("is_press %0b, want %0b (code %0d)",
                                      is_press_o, want.press, want.code));
          if (last_of_poll_o !== want.last)
            report_mismatch($sformatf("last_of_poll %0b, want %0b (code %0d)",
                                      last_of_poll_o, want.last, want.code));
        end
      end
      if (in_valid_i && in_ready_o) begin
        busy = 1'b1;
        predict_poll(horizontal_sample_i, vertical_sample_i, strafe_press_i);
      end
      if (psel && penable && pwrite && pready) begin
        busy = 1'b1;
        case (reg_idx_e'(paddr[3:2]))
          REG_HCENTER: hcenter_m = pwdata[CENTER_BITS-1:0];
          REG_VCENTER: vcenter_m = pwdata[CENTER_BITS-1:0];
          REG_HALF:    half_m    = pwdata[HALF_BITS-1:0];
          REG_MARGIN:  margin_m  = pwdata[HALF_BITS-1:0];
          default: ;
        endcase
      end
    end
    if (busy) idle_cycles = 0;
    else idle_cycles++;
  end

  // Abort a hung run: nothing has moved for too long
  initial begin
    wait (rst_ni);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("tb_joystick_deadzone_key_events_top: done, errors");
    $finish;
  end

  // Back-pressure on the event channel: runs of ready, then random stalls
  initial begin : event_sink
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      stall = gap_len();
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Send one poll request. Hold valid across back-to-back polls so it is
  // never dropped and raised in the same step.
  task automatic send_poll(input logic [SAMPLE_BITS-1:0] h,
                           input logic [SAMPLE_BITS-1:0] v,
                           input logic s);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    horizontal_sample_i <= h;
    vertical_sample_i   <= v;
    strafe_press_i      <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid, wait for every owed event, then let a silent poll finish
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_keys.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the write lands when pready is seen
  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned h, input int unsigned v,
                            input int unsigned half, input int unsigned margin);
    cfg_write(REG_HCENTER, h);
    cfg_write(REG_VCENTER, v);
    cfg_write(REG_HALF, half);
    cfg_write(REG_MARGIN, margin);
  endtask

  // Aim most samples at the band edges (plain and pulled in), some at the
  // center, the rails, or anywhere at all.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int c);
    int half;
    int margin;
    int base;
    half   = int'(half_m);
    margin = int'(margin_m);
    case ($urandom_range(0, 6))
      0: base = c - half;
      1: base = c - half + margin;
      2: base = c + half;
      3: base = c + half - margin;
      4: base = c;
      5: base = $urandom_range(0, 1) ? 0 : SAMPLE_MAX;
      default: base = $urandom_range(0, SAMPLE_MAX);
    endcase
    base = base + int'($urandom_range(0, 8)) - 4;
    if (base < 0) base = 0;
    else if (base > SAMPLE_MAX) base = SAMPLE_MAX;
    return base[SAMPLE_BITS-1:0];
  endfunction

  task automatic run_random(input int unsigned count);
    repeat (count) begin
      send_poll(pick_sample(int'(hcenter_m)), pick_sample(int'(vcenter_m)),
                ($urandom_range(0, 4) == 0));
    end
    settle();
  endtask

  // Reset values: horizontal band 900..2100, vertical band 1448..2648
  task automatic test_default_bands();
    send_poll(12'd1500, 12'd2048, 1'b0);  // neutral, no event
    send_poll(12'd899,  12'd2048, 1'b0);  // just past low edge: press left
    send_poll(12'd1000, 12'd2048, 1'b0);  // inside band but under pulled edge
    send_poll(12'd1100, 12'd2048, 1'b0);  // on pulled edge: release left
    send_poll(12'd2101, 12'd2048, 1'b0);  // press right
    send_poll(12'd1900, 12'd2048, 1'b0);  // on pulled high edge: release
    send_poll(12'd0,    12'd0,    1'b0);  // press left and up
    send_poll(12'd4095, 12'd4095, 1'b0);  // full swing: four events
    send_poll(12'd2000, 12'd2700, 1'b0);  // wobble while held: nothing
    send_poll(12'd1500, 12'd2048, 1'b0);  // release both axes
    settle();
  endtask

  // Releases take the code of the current mode, not the one the press used
  task automatic test_strafe_mode();
    send_poll(12'd0,    12'd2048, 1'b1);  // strafe on, press strafe left
    send_poll(12'd0,    12'd2048, 1'b1);  // strafe off while held: nothing
    send_poll(12'd1500, 12'd2048, 1'b1);  // strafe on, release as strafe left
    send_poll(12'd4095, 12'd2048, 1'b0);  // press strafe right
    send_poll(12'd1500, 12'd2048, 1'b1);  // strafe off, release as right
    settle();
  endtask

  // Zero-width band with a margin wide enough to cross the edges, then
  // bands that run past both rails.
  task automatic test_crossed_edges();
    set_config(2048, 2048, 0, 2047);
    send_poll(12'd2048, 12'd2048, 1'b0);  // exactly on a zero-width band
    send_poll(12'd2047, 12'd2049, 1'b0);  // press left, press down
    send_poll(12'd2048, 12'd2048, 1'b0);  // crossed edges keep both held
    send_poll(12'd4095, 12'd0,    1'b0);  // flip both axes: four events
    settle();
    set_config(0, 4095, 2047, 0);
    send_poll(12'd0,    12'd4095, 1'b0);  // in band at both rails: releases
    send_poll(12'd2048, 12'd2047, 1'b0);  // press right, press up
    settle();
  endtask

  task automatic test_random_traffic();
    set_config(HCENTER_RST, VCENTER_RST, HALF_RST, MARGIN_RST);
    run_random(25);
    // Full 32-bit words: the upper bits must be dropped
    cfg_write(REG_HCENTER, $urandom());
    cfg_write(REG_VCENTER, $urandom());
    cfg_write(REG_HALF, $urandom());
    cfg_write(REG_MARGIN, $urandom());
    run_random(20);
    set_config(4095, 0, 0, 0);
    run_random(12);
    set_config($urandom_range(0, 4095), $urandom_range(0, 4095),
               $urandom_range(0, 15), $urandom_range(1024, 2047));
    run_random(12);
    // Stretch with no gaps and no stalls
    quiet = 1'b1;
    set_config($urandom_range(1000, 3000), $urandom_range(1000, 3000),
               $urandom_range(100, 800), $urandom_range(0, 300));
    run_random(20);
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_valid_i          = 1'b0;
    horizontal_sample_i = '0;
    vertical_sample_i   = '0;
    strafe_press_i      = 1'b0;
    mismatch_count      = 0;
    idle_cycles         = 0;
    quiet               = 1'b0;
    hcenter_m           = HCENTER_RST;
    vcenter_m           = VCENTER_RST;
    half_m              = HALF_RST;
    margin_m            = MARGIN_RST;
    left_m              = 1'b0;
    right_m             = 1'b0;
    up_m                = 1'b0;
    down_m              = 1'b0;
    strafe_m            = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_bands();
    test_strafe_mode();
    test_crossed_edges();
    test_random_traffic();
    settle();

    if (mismatch_count == 0 && pending_keys.size() == 0) begin
      $display("tb_joystick_deadzone_key_events_top: done, clean");
    end else begin
      $display("tb_joystick_deadzone_key_events_top: done, errors");
    end
    $finish;
  end

endmodule
